// ----- rtl/bdlp_pkg.sv -----
// Shared types and constants for the debounced button with long-press detection.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdlp_pkg;

    localparam int DEB_W  = 16;
    localparam int HOLD_W = 24;
    localparam int EV_W   = 3;

    // Event codes carried in the result word.
    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_PRESS      = 3'd1;
    localparam logic [EV_W-1:0] EV_SHORT_REL  = 3'd2;
    localparam logic [EV_W-1:0] EV_LONG_PRESS = 3'd3;
    localparam logic [EV_W-1:0] EV_LONG_REL   = 3'd4;

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_PRESSED_LV = 2'd2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 16'd10;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 24'd2000;
    localparam logic              PRESSED_LV_RESET = 1'b0;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
        logic              pressed_level;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/button_debounce_long_press.sv -----
// Top level of the debounced push button with press, release and long-press events.
// Depends on bdlp_pkg, bdlp_cfg_regs and bdlp_core.
//
// Usage:
// The slave stream carries one word per tick of the button sample clock. Each
// accepted word produces exactly one result word on the master stream, holding
// the event of that tick (none, press, short release, long press, long release)
// and the debounced pressed state after the tick.
// The result is registered: a word accepted in a cycle shows its result in
// the next. Throughput is one word per cycle while the receiver takes each
// result; the debounce countdown, the hold counter increment and the limit
// compares all settle between the input handshake and the result register.
// When the receiver stalls, the result register holds its word and s_tready
// drops until the word is taken; a word is accepted in the same cycle the
// pending result leaves, so a steady stream never loses a cycle.
// Reset (aresetn low, synchronous) empties the result register, clears all
// counters and the debounced state to released, and reloads the configuration
// registers: debounce 10 ticks, long press 2000 ticks, pressed level 0.
// Configuration is written over the APB-style port at byte addresses 0, 4 and 8
// while the stream is idle; reads return the stored values.
`default_nettype none

module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] raw_level, [1] enable, [7:2] zero

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [2:0] event_res, [3] pressed, [7:4] zero

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t            cfg;
    logic [EV_W-1:0] event_res;
    logic            pressed;

    bdlp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The upper bits of the input word carry nothing and are ignored.
    bdlp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_level (s_tdata[0]),
        .enable    (s_tdata[1]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .event_res (event_res),
        .pressed   (pressed)
    );

    assign m_tdata = {4'd0, pressed, event_res};

endmodule

`default_nettype wire

// ----- rtl/bdlp_cfg_regs.sv -----
// APB-style register file holding the debounce and long-press settings.
// Depends on bdlp_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module bdlp_cfg_regs
    import bdlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [DEB_W-1:0]  debounce_reg;
    logic [HOLD_W-1:0] long_press_reg;
    logic              pressed_lv_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            pressed_lv_reg <= PRESSED_LV_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DEBOUNCE:   debounce_reg   <= pwdata[DEB_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[HOLD_W-1:0];
                REG_PRESSED_LV: pressed_lv_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEBOUNCE:   prdata = {{(32-DEB_W){1'b0}}, debounce_reg};
            REG_LONG_PRESS: prdata = {{(32-HOLD_W){1'b0}}, long_press_reg};
            REG_PRESSED_LV: prdata = {31'd0, pressed_lv_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.debounce_ticks   = debounce_reg;
    assign cfg.long_press_ticks = long_press_reg;
    assign cfg.pressed_level    = pressed_lv_reg;

endmodule

`default_nettype wire

// ----- rtl/bdlp_core.sv -----
// Debounce countdown, hold counter and event decode, with the result register.
// Depends on bdlp_pkg for the event codes, widths and cfg_t.
`default_nettype none

module bdlp_core
    import bdlp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       raw_level,
    input  wire logic       enable,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [EV_W-1:0] event_res,
    output logic            pressed
);

    logic              last_raw_reg,   last_raw_next;
    logic [DEB_W-1:0]  deb_left_reg,   deb_left_next;
    logic              deb_armed_reg,  deb_armed_next;
    logic              stable_reg,     stable_next;
    logic [HOLD_W-1:0] hold_reg,       hold_next;
    logic              running_reg,    running_next;
    logic              out_valid_reg;
    logic [EV_W-1:0]   event_reg,      event_next;
    logic              pressed_reg;

    logic [HOLD_W-1:0] limit;
    logic [DEB_W-1:0]  deb_load;
    logic [DEB_W-1:0]  deb_dec;
    logic              expired;
    logic              now_pressed;
    logic              accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign limit    = (cfg.long_press_ticks == '0) ? HOLD_W'(1) : cfg.long_press_ticks;
    assign deb_load = (cfg.debounce_ticks == '0) ? DEB_W'(1) : cfg.debounce_ticks;
    assign deb_dec  = (deb_left_reg != '0) ? deb_left_reg - DEB_W'(1) : '0;
    assign now_pressed = (raw_level == cfg.pressed_level);

    always_comb begin
        hold_next      = hold_reg;
        running_next   = running_reg;
        event_next     = EV_NONE;
        deb_left_next  = deb_left_reg;
        deb_armed_next = deb_armed_reg;
        stable_next    = stable_reg;
        expired        = 1'b0;

        // The hold counter advances first, saturating at full scale.
        if (running_reg) begin
            if (hold_reg != HOLD_MAX) begin
                hold_next = hold_reg + HOLD_W'(1);
            end
            if (hold_next == limit) begin
                event_next   = EV_LONG_PRESS;
                running_next = 1'b0;
            end
        end

        if (raw_level != last_raw_reg) begin
            deb_left_next  = deb_load;
            deb_armed_next = 1'b1;
        end else if (deb_armed_reg) begin
            deb_left_next = deb_dec;
            if (deb_dec == '0) begin
                deb_armed_next = 1'b0;
                expired        = 1'b1;
            end
        end

        // A release is judged with the count already advanced on this tick.
        if (expired) begin
            stable_next = now_pressed;
            if ((now_pressed != stable_reg) && enable) begin
                if (now_pressed) begin
                    event_next   = EV_PRESS;
                    hold_next    = '0;
                    running_next = 1'b1;
                end else begin
                    running_next = 1'b0;
                    event_next   = (hold_next < limit) ? EV_SHORT_REL : EV_LONG_REL;
                    hold_next    = '0;
                end
            end
        end
    end

    assign last_raw_next = raw_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg  <= 1'b1;
            deb_left_reg  <= '0;
            deb_armed_reg <= 1'b0;
            stable_reg    <= 1'b0;
            hold_reg      <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                last_raw_reg  <= last_raw_next;
                deb_left_reg  <= deb_left_next;
                deb_armed_reg <= deb_armed_next;
                stable_reg    <= stable_next;
                hold_reg      <= hold_next;
                running_reg   <= running_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            event_reg   <= event_next;
            pressed_reg <= stable_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign pressed   = pressed_reg;

endmodule

`default_nettype wire

// ----- rtl/bdlp_checker.sv -----
// Port-level checks for the debounced button block, bound to its top level.
// Depends on bdlp_pkg for the event codes.
`default_nettype none

module bdlp_checker
    import bdlp_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled result keeps its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // Every accepted word yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // A press is only seen while the button is down. A long press is not tied to
    // the state: after a release with events off the hold counter keeps running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == EV_PRESS) |-> m_tdata[3])
        else $error("press event with released state");

    // Releases leave the button up, and no undefined event code appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] != EV_SHORT_REL && m_tdata[2:0] != EV_LONG_REL
                      || !m_tdata[3]) && m_tdata[2:0] <= EV_LONG_REL)
        else $error("bad release state or event code");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- bench/button_debounce_long_press_checker.sv -----
`timescale 1ns / 100ps
// Watches the tick and result streams and the register port of the debounced button.
// Predicts each result word and checks it field by field. Uses bdlp_pkg for codes.

module button_debounce_long_press_checker
    import bdlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] raw_level, [1] enable, [7:2] zero
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [2:0] event_res, [3] pressed, [7:4] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               errors,
    output int               outstanding,
    output int               words_checked
);

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic            pressed;
    } button_word_t;

    // Register copies.
    logic [DEB_W-1:0]  deb_cfg;
    logic [HOLD_W-1:0] long_cfg;
    logic              lvl_cfg;

    // Button state.
    logic              last_raw_q;
    logic [DEB_W-1:0]  deb_left;
    logic              deb_armed;
    logic              stable_q;
    logic [HOLD_W-1:0] hold_q;
    logic              hold_run;

    button_word_t button_words[$];
    button_word_t predicted;
    button_word_t oldest;
    logic [31:0]  reg_value;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // One tick of the button: hold counter first, then the debounce countdown,
    // then the press or release decision on expiry.
    task automatic tick_button(input logic raw, input logic en, output button_word_t w);
        logic [HOLD_W-1:0] limit;
        logic              expired;
        logic              now_pressed;
        limit     = (long_cfg == '0) ? HOLD_W'(1) : long_cfg;
        w.ev      = EV_NONE;
        expired   = 1'b0;
        if (hold_run) begin
            if (hold_q != HOLD_MAX)
                hold_q = hold_q + HOLD_W'(1);
            if (hold_q == limit) begin
                w.ev     = EV_LONG_PRESS;
                hold_run = 1'b0;
            end
        end
        if (raw != last_raw_q) begin
            deb_left  = (deb_cfg == '0) ? DEB_W'(1) : deb_cfg;
            deb_armed = 1'b1;
        end else if (deb_armed) begin
            if (deb_left != '0)
                deb_left = deb_left - DEB_W'(1);
            if (deb_left == '0) begin
                deb_armed = 1'b0;
                expired   = 1'b1;
            end
        end
        last_raw_q = raw;
        if (expired) begin
            now_pressed = (raw == lvl_cfg);
            if (now_pressed != stable_q && en) begin
                if (now_pressed) begin
                    w.ev     = EV_PRESS;
                    hold_q   = '0;
                    hold_run = 1'b1;
                end else begin
                    // A release on the limit tick overrides the long press event.
                    hold_run = 1'b0;
                    w.ev     = (hold_q < limit) ? EV_SHORT_REL : EV_LONG_REL;
                    hold_q   = '0;
                end
            end
            stable_q = now_pressed;
        end
        w.pressed = stable_q;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            deb_cfg       = DEBOUNCE_RESET;
            long_cfg      = LONG_PRESS_RESET;
            lvl_cfg       = PRESSED_LV_RESET;
            last_raw_q    = ~PRESSED_LV_RESET;
            deb_left      = '0;
            deb_armed     = 1'b0;
            stable_q      = 1'b0;
            hold_q        = '0;
            hold_run      = 1'b0;
            button_words.delete();
            outstanding   <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_DEBOUNCE:   deb_cfg  = pwdata[DEB_W-1:0];
                        REG_LONG_PRESS: long_cfg = pwdata[HOLD_W-1:0];
                        REG_PRESSED_LV: lvl_cfg  = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        REG_DEBOUNCE:   reg_value = 32'(deb_cfg);
                        REG_LONG_PRESS: reg_value = 32'(long_cfg);
                        REG_PRESSED_LV: reg_value = 32'(lvl_cfg);
                        default:        reg_value = prdata;
                    endcase
                    if (prdata !== reg_value)
                        report_mismatch("register read", prdata, reg_value);
                end
            end
            if (s_tvalid && s_tready) begin
                tick_button(s_tdata[0], s_tdata[1], predicted);
                button_words.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                if (button_words.size() == 0) begin
                    report_mismatch("result word with none expected", 32'(m_tdata), '0);
                end else begin
                    oldest = button_words.pop_front();
                    if (m_tdata[2:0] !== oldest.ev)
                        report_mismatch("event", 32'(m_tdata[2:0]), 32'(oldest.ev));
                    if (m_tdata[3] !== oldest.pressed)
                        report_mismatch("pressed", 32'(m_tdata[3]), 32'(oldest.pressed));
                    if (m_tdata[7:4] !== 4'b0)
                        report_mismatch("padding", 32'(m_tdata[7:4]), '0);
                    words_checked++;
                end
            end
            outstanding <= button_words.size();
        end
    end

endmodule

// ----- bench/button_debounce_long_press_tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the debounced button: clock, reset, stimulus and verdict.
// Needs bdlp_pkg, the block and button_debounce_long_press_checker.

module button_debounce_long_press_tb
    import bdlp_pkg::*;
();

    // Generous ceiling: about 1800 ticks with sender gaps, long receiver stalls
    // and register traffic stay far below this.
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] raw_level, [1] enable, [7:2] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [2:0] event_res, [3] pressed, [7:4] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int outstanding;
    int words_checked;
    int cycle_count   = 0;
    int items_sent    = 0;
    int settings_count = 0;
    int words_taken   = 0;

    // Sender-side state: whether gaps are drawn in the current stretch, the pin
    // level the gesture generator is on, and the active debounce and limit.
    logic sender_gaps = 1'b1;
    logic receiver_gaps = 1'b1;
    logic pin_level = 1'b1;
    int   cur_deb;
    int   cur_long;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    button_debounce_long_press dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    button_debounce_long_press_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    // Watchdog: a hung handshake or a result that never arrives ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("button_debounce_long_press_tb: done, errors");
            $finish;
        end
    end

    // Offers one tick word and waits for it to be taken. The gap before the
    // word lowers tvalid only in a different time step from the raise, so
    // back-to-back words keep tvalid high without a glitch.
    task automatic send_tick(input logic raw, input logic en);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, en, raw};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        // Switch between gappy and gap-free stretches now and then.
        if (items_sent % 100 == 0)
            sender_gaps = 1'($urandom_range(0, 1));
    endtask

    task automatic hold_level(input logic raw, input logic en, input int n);
        repeat (n) send_tick(raw, en);
        pin_level = raw;
    endtask

    // Setup cycle, access cycle, then an idle cycle so that psel is never
    // lowered and raised again in the same time step.
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // The sender stops and waits until every expected word has come back.
    // Each tick always yields a word, so an empty expectation store means
    // the block is idle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Registers change only with the stream drained; each write is read back.
    task automatic apply_settings(input logic [15:0] deb, input logic [23:0] lim,
                                  input logic lvl);
        wait_drained();
        apb_access(1'b1, REG_DEBOUNCE, 32'(deb));
        apb_access(1'b1, REG_LONG_PRESS, 32'(lim));
        apb_access(1'b1, REG_PRESSED_LV, 32'(lvl));
        apb_access(1'b0, REG_DEBOUNCE, '0);
        apb_access(1'b0, REG_LONG_PRESS, '0);
        apb_access(1'b0, REG_PRESSED_LV, '0);
        cur_deb  = (deb == 16'd0) ? 1 : int'(deb);
        cur_long = (lim == 24'd0) ? 1 : int'(lim);
        settings_count++;
    endtask

    // Mostly clean gestures: the pin flips, optionally with contact bounce,
    // then rests for a random time that often spans debounce plus the long
    // press limit, so presses, releases of both kinds and long presses all
    // come up. One gesture in ten is plain noise on both bits.
    task automatic play_gestures(input int count);
        int   sent;
        int   span;
        int   len;
        int   k;
        logic en;
        sent = 0;
        span = cur_deb + cur_long + 6;
        if (span > 60)
            span = 60;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    pin_level = 1'($urandom_range(0, 1));
                    send_tick(pin_level, 1'($urandom_range(0, 1)));
                end
                sent += len;
            end else begin
                en        = ($urandom_range(0, 7) != 0);
                pin_level = !pin_level;
                len       = $urandom_range(0, 2);
                for (k = 0; k < len; k++) begin
                    send_tick(pin_level, en);
                    send_tick(!pin_level, en);
                end
                sent += 2 * len;
                len = $urandom_range(1, span);
                hold_level(pin_level, en, len);
                sent += len;
            end
        end
    endtask

    // Receiver: random stalls per word, stretches without stalls, and two long
    // hold-offs during which the sender keeps offering so the block backs up
    // and drops s_tready.
    initial begin
        int hold;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (words_taken == 150 || words_taken == 1000)
                hold = 50;
            else
                hold = receiver_gaps ? $urandom_range(0, 6) : 0;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            words_taken++;
            if (words_taken % 80 == 0)
                receiver_gaps = 1'($urandom_range(0, 1));
        end
    end

    // Stimulus and verdict.
    initial begin
        int ph;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_deb  = int'(DEBOUNCE_RESET);
        cur_long = int'(LONG_PRESS_RESET);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values of all registers first.
        apb_access(1'b0, REG_DEBOUNCE, '0);
        apb_access(1'b0, REG_LONG_PRESS, '0);
        apb_access(1'b0, REG_PRESSED_LV, '0);

        // Directed part with zero debounce (acts as one tick) and a limit of
        // three, pull-up wiring so the pin reads 0 when pressed.
        apply_settings(16'd0, 24'd3, 1'b0);
        hold_level(1'b0, 1'b1, 5);      // press, then long press after three
        hold_level(1'b1, 1'b1, 2);      // release after the long press: long
        hold_level(1'b0, 1'b1, 2);      // press
        hold_level(1'b1, 1'b1, 2);      // release before the limit: short
        hold_level(1'b0, 1'b1, 3);      // press, release lands on the limit tick,
        hold_level(1'b1, 1'b1, 2);      // so it is long and the long press drops
        hold_level(1'b0, 1'b0, 2);      // disabled: state follows, no events
        hold_level(1'b1, 1'b0, 2);
        hold_level(1'b0, 1'b1, 2);      // press starts the counter
        hold_level(1'b1, 1'b0, 2);      // disabled release keeps it running,
        hold_level(1'b0, 1'b1, 2);      // long press fires, then a press restarts it
        hold_level(1'b1, 1'b1, 2);      // short release

        // Setting extremes.
        apply_settings(16'd1, 24'd1, 1'b1);
        play_gestures(60);
        apply_settings(16'hFFFF, HOLD_MAX, 1'b0);
        play_gestures(40);
        apply_settings(16'd0, 24'd0, 1'b1);
        play_gestures(60);
        apply_settings(DEBOUNCE_RESET, LONG_PRESS_RESET, PRESSED_LV_RESET);
        play_gestures(40);

        // Random settings with short debounce and limits so that long presses
        // and every release kind come up often.
        for (ph = 0; ph < 12; ph++) begin
            apply_settings(16'($urandom_range(0, 12)), 24'($urandom_range(0, 40)),
                           1'($urandom_range(0, 1)));
            play_gestures(130);
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("Sent %0d button ticks over %0d register settings; %0d result words compared.",
                 items_sent, settings_count, words_checked);
        $display("Covered bounce, disabled events, long and short releases, both wirings.");
        if (errors == 0)
            $display("button_debounce_long_press_tb: done, clean");
        else
            $display("button_debounce_long_press_tb: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bdlp_pkg.sv
rtl/bdlp_cfg_regs.sv
rtl/bdlp_core.sv
rtl/button_debounce_long_press.sv
rtl/bdlp_checker.sv
bench/button_debounce_long_press_checker.sv
bench/button_debounce_long_press_tb.sv
